// ===== rtl/lss_pkg.sv =====
// ----------------------------------------------------------------------------
// lss_pkg: shared types and constants of the line sensor steering block
// Field widths, sensor weights and the sensor scan function.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int SENS_W  = 8;   // sensor pattern
  localparam int SPEED_W = 11;  // base speed
  localparam int GAIN_W  = 16;  // steering gain, Q8.8
  localparam int SUM_W   = 7;   // signed weighted sum
  localparam int MAG_W   = 6;   // error magnitude before division
  localparam int CNT_W   = 4;   // count of set bits, also the divisor
  localparam int PROD_W  = MAG_W + GAIN_W;
  localparam int FRAC_W  = 8;   // fraction bits of the gain
  localparam int QUO_W   = PROD_W - FRAC_W;
  localparam int ERR_FRAC_W = 4;
  localparam int ERR_W   = 11;
  localparam int SET_W   = 15;
  localparam int IN_W    = 24;
  localparam int OUT_W   = 48;

  localparam logic [GAIN_W-1:0] GAIN_RST = 16'd256;
  localparam logic [MAG_W-1:0]  LOST_MAG = 6'd40;

  typedef logic signed [SUM_W-1:0] wsum_t;

  localparam wsum_t WEIGHT [SENS_W] = '{
    -7'sd24, -7'sd12, -7'sd6, -7'sd4, 7'sd4, 7'sd6, 7'sd12, 7'sd24
  };

  typedef struct packed {
    wsum_t             sum;
    logic [CNT_W-1:0]  cnt;
  } scan_t;

  function automatic scan_t sensor_scan(input logic [SENS_W-1:0] bits);
    scan_t r;
    r.sum = '0;
    r.cnt = '0;
    for (int i = 0; i < SENS_W; i++) begin
      if (bits[i]) begin
        r.sum = r.sum + WEIGHT[i];
        r.cnt = r.cnt + 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/lss_mul.sv =====
// ----------------------------------------------------------------------------
// lss_mul: bit-serial shift-add multiplier
// Consumes one bit of b per cycle, LSB first, with a narrow adder on a.
// ----------------------------------------------------------------------------
module lss_mul import lss_pkg::*; #(
  parameter int A_W = MAG_W,
  parameter int B_W = GAIN_W
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [A_W-1:0]     a_i,
  input  logic [B_W-1:0]     b_i,
  output logic               done_o,
  output logic [A_W+B_W-1:0] prod_o
);

  localparam int P_W = A_W + B_W;
  localparam int CW  = (B_W > 1) ? $clog2(B_W) : 1;

  logic [P_W-1:0] prod_q, prod_d;
  logic [A_W-1:0] a_q;
  logic [A_W:0]   acc;
  logic [CW-1:0]  cnt_q;
  logic           busy_q, done_q;

  // add a into the upper part when the current multiplier bit is set, then shift
  always_comb begin
    acc    = {1'b0, prod_q[P_W-1:B_W]} + (prod_q[0] ? {1'b0, a_q} : '0);
    prod_d = {acc, prod_q[B_W-1:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(B_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= {{A_W{1'b0}}, b_i};
      a_q    <= a_i;
    end else if (busy_q) begin
      prod_q <= prod_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

// ===== rtl/lss_div.sv =====
// ----------------------------------------------------------------------------
// lss_div: bit-serial restoring divider
// One quotient bit per cycle, MSB first, remainder as narrow as the divisor.
// ----------------------------------------------------------------------------
module lss_div import lss_pkg::*; #(
  parameter int DVD_W = QUO_W,
  parameter int DSR_W = CNT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  localparam int CW = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic [DVD_W-1:0] quo_q;
  logic [DSR_W-1:0] dsr_q, rem_q, rem_d;
  logic [DSR_W:0]   trial, diff;
  logic             ge;
  logic [CW-1:0]    cnt_q;
  logic             busy_q, done_q;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
    rem_d = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DVD_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // dividend shifts out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DVD_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/line_sensor_steering_top.sv =====
// Path: an accepted input beat runs through 16 multiply steps (one gain bit each), then
// 14 divide steps (one quotient bit each) and the S_FIN handoff to the output register.
// Flow: one item at a time, input taken only in S_IDLE; the serial multiplier, the shared
// serial divider and an output stall hold it; the error division runs beside the multiply.
// Reset: asynchronous, active low; clears the FSM, the output valid, the stored
// error sign and sets the steering gain to 1.0 (256).
// ----------------------------------------------------------------------------
// line_sensor_steering_top: weighted-centroid line follower steering
// Turns an 8-bit sensor pattern and a base speed into left/right setpoints.
// ----------------------------------------------------------------------------
module line_sensor_steering_top import lss_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [GAIN_W-1:0] cfg_wdata_i,    // steer_gain, unsigned Q8.8
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [IN_W-1:0]   s_axis_tdata,   // [7:0] sensor_bits, [18:8] cruise_speed
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata,   // [14:0] left_setpoint,
                                            // [29:15] right_setpoint, [40:30] line_error
  output logic              m_axis_tuser    // line_lost
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FIN
  } state_e;

  state_e              state_q;
  logic [GAIN_W-1:0]   gain_q;
  logic                lep_q;
  logic                neg_q, lost_q;
  logic [CNT_W-1:0]    dsr_q;
  logic [SPEED_W-1:0]  base_q;
  logic [ERR_W-1:0]    err_mag_q;
  logic                out_valid_q, out_user_q;
  logic [OUT_W-1:0]    out_data_q;

  scan_t               scan;
  logic                in_acc, lost_d, sum_neg, neg_d;
  wsum_t               abs_sum;
  logic [MAG_W-1:0]    mag_d;
  logic [CNT_W-1:0]    dsr_d;

  logic                mul_done, div_start, div_done;
  logic [PROD_W-1:0]   prod;
  logic [QUO_W-1:0]    div_dvd, quo;
  logic [CNT_W-1:0]    div_dsr;

  logic signed [SET_W-1:0] base_x, turn, left_sp, right_sp;
  logic [ERR_W-1:0]        err_out;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // classify the pattern; a lost line behaves as magnitude 40 over a count of one
  always_comb begin
    scan    = sensor_scan(s_axis_tdata[SENS_W-1:0]);
    lost_d  = (scan.cnt == '0);
    sum_neg = scan.sum[SUM_W-1];
    abs_sum = sum_neg ? -scan.sum : scan.sum;
    mag_d   = lost_d ? LOST_MAG : abs_sum[MAG_W-1:0];
    dsr_d   = lost_d ? CNT_W'(1) : scan.cnt;
    neg_d   = lost_d ? !lep_q : sum_neg;
  end

  assign div_start = in_acc || ((state_q == S_MUL) && mul_done);
  assign div_dvd   = (state_q == S_IDLE)
                   ? QUO_W'({mag_d, {ERR_FRAC_W{1'b0}}})
                   : prod[PROD_W-1:FRAC_W];
  assign div_dsr   = (state_q == S_IDLE) ? dsr_d : dsr_q;

  lss_mul #(
    .A_W (MAG_W),
    .B_W (GAIN_W)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (mag_d),
    .b_i     (gain_q),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  lss_div #(
    .DVD_W (QUO_W),
    .DSR_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    base_x   = SET_W'(signed'(base_q));
    turn     = neg_q ? -signed'({1'b0, quo}) : signed'({1'b0, quo});
    left_sp  = base_x - turn;
    right_sp = base_x + turn;
    err_out  = neg_q ? -err_mag_q : err_mag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lep_q       <= 1'b0;
      neg_q       <= 1'b0;
      lost_q      <= 1'b0;
      dsr_q       <= '0;
      base_q      <= '0;
      err_mag_q   <= '0;
      out_valid_q <= 1'b0;
      out_user_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      // S_FIN reloads the output register itself
      if (out_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            neg_q   <= neg_d;
            lost_q  <= lost_d;
            dsr_q   <= dsr_d;
            base_q  <= s_axis_tdata[SENS_W +: SPEED_W];
            // a lost line keeps the stored sign
            if (!lost_d) begin
              lep_q <= !sum_neg && (scan.sum != '0);
            end
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (div_done) begin
            err_mag_q <= quo[ERR_W-1:0];
          end
          if (mul_done) begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // hold the result until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_user_q  <= lost_q;
            out_data_q  <= OUT_W'({err_out, right_sp, left_sp});
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

// ===== rtl/lss_checker.sv =====
// ----------------------------------------------------------------------------
// lss_checker: port-level assertions for the line sensor steering block
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module lss_checker import lss_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_W-1:0]  m_axis_tdata,
  input logic              m_axis_tuser
);

  localparam logic [ERR_W-1:0] ERR_LOST_POS = 11'h280;  // +640
  localparam logic [ERR_W-1:0] ERR_LOST_NEG = 11'h580;  // -640

  logic [ERR_W-1:0] err_f;
  assign err_f = m_axis_tdata[2*SET_W +: ERR_W];

  // one item in flight: a beat taken closes the input side for the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in flight");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

  // a lost line reports the full-scale error
  a_lost_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> (err_f == ERR_LOST_POS) || (err_f == ERR_LOST_NEG))
    else $error("lost line without full-scale error");

  // a seen line never reaches the full-scale error
  a_seen_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> (err_f != ERR_LOST_POS) && (err_f != ERR_LOST_NEG))
    else $error("seen line with full-scale error");

endmodule

bind line_sensor_steering_top lss_checker u_lss_checker (.*);

// ===== test/tb_line_sensor_steering_top.sv =====
// ----------------------------------------------------------------------------
// tb_line_sensor_steering_top: self-checking bench for line_sensor_steering_top
// Drives sensor/speed beats under random stalls on both streams, predicts the
// wheel setpoints, error and lost flag per beat and compares every output beat.
// The gain register is swept across its extremes between drained phases.
// ----------------------------------------------------------------------------
module tb_line_sensor_steering_top;
  import lss_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;    // settle time at the end, longer than the block's latency
  localparam int PHASE_BEATS   = 150;
  localparam int LOST_ERR      = 40;
  localparam int SENSOR_WEIGHT [8] = '{-24, -12, -6, -4, 4, 6, 12, 24};

  typedef struct {
    logic signed [SET_W-1:0] left;
    logic signed [SET_W-1:0] right;
    logic signed [ERR_W-1:0] err;
    logic                    lost;
  } wheel_cmd_t;

  class steer_scoreboard;
    int unsigned gain;
    bit          last_pos;
    wheel_cmd_t  pending_cmds [$];
    int          errors;

    function new();
      gain     = 256;
      last_pos = 1'b0;
      errors   = 0;
    endfunction

    function void set_gain(logic [GAIN_W-1:0] g);
      gain = g;
    endfunction

    function int pending();
      return pending_cmds.size();
    endfunction

    // Work out the setpoints for one accepted sensor beat.
    function void predict_sensor_beat(logic [SENS_W-1:0] bits,
                                      logic signed [SPEED_W-1:0] spd);
      int         sum;
      int         cnt;
      int         lost_err;
      longint     turn;
      longint     err16;
      wheel_cmd_t cmd;
      sum = 0;
      cnt = 0;
      for (int i = 0; i < SENS_W; i++) begin
        if (bits[i]) begin
          sum += SENSOR_WEIGHT[i];
          cnt++;
        end
      end
      if (cnt == 0) begin
        // line lost: steer hard toward the side it was last seen, keep sign
        lost_err = last_pos ? LOST_ERR : -LOST_ERR;
        err16    = longint'(lost_err) * 16;
        turn     = (longint'(lost_err) * longint'(gain)) / 256;
      end else begin
        err16    = (longint'(sum) * 16) / cnt;
        turn     = (longint'(sum) * longint'(gain)) / (longint'(cnt) * 256);
        last_pos = (sum > 0);
      end
      cmd.left  = SET_W'(longint'(spd) - turn);
      cmd.right = SET_W'(longint'(spd) + turn);
      cmd.err   = ERR_W'(err16);
      cmd.lost  = (cnt == 0);
      pending_cmds.push_back(cmd);
    endfunction

    function void compare_field(string name, logic signed [63:0] exp_v,
                                logic signed [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_wheel_beat(logic [OUT_W-1:0] data, logic lost);
      wheel_cmd_t cmd;
      if (pending_cmds.size() == 0) begin
        errors++;
        $display("%0t: output beat with nothing pending: expected none, got %h lost=%b",
                 $time, data, lost);
        return;
      end
      cmd = pending_cmds.pop_front();
      compare_field("left_setpoint", cmd.left, $signed(data[14:0]));
      compare_field("right_setpoint", cmd.right, $signed(data[29:15]));
      compare_field("line_error", cmd.err, $signed(data[40:30]));
      compare_field("line_lost", cmd.lost, lost);
      compare_field("tdata padding", 0, data[OUT_W-1:41]);
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [GAIN_W-1:0]    cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 m_axis_tuser;

  steer_scoreboard sb = new();
  bit              gaps_on = 1'b1;
  int              rx_hold = 0;
  int              cycle_cnt = 0;

  line_sensor_steering_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Output side: check accepted beats, then choose next tready.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_wheel_beat(m_axis_tdata, m_axis_tuser);
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 12) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic logic [SENS_W-1:0] pick_pattern();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 8'h01 << $urandom_range(0, 7);
      default: return SENS_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [SPEED_W-1:0] pick_speed();
    case ($urandom_range(0, 9))
      0:       return -11'sd1024;
      1:       return 11'sd1023;
      default: return SPEED_W'($urandom);
    endcase
  endfunction

  // Offer one beat and hold it until accepted; valid stays high afterward.
  task automatic send_sensor_beat(input logic [SENS_W-1:0] bits,
                                  input logic signed [SPEED_W-1:0] spd);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, spd, bits};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.predict_sensor_beat(bits, spd);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_gain(g);
  endtask

  initial begin
    logic [SENS_W-1:0]  dir_bits [$];
    logic [GAIN_W-1:0]  phase_gain [6];

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset gain: lost line from both signs, cancelling
    // patterns, every single sensor, truncating quotients, speed extremes.
    dir_bits = '{8'h00, 8'h80, 8'h00, 8'hFF, 8'h00, 8'h01, 8'h02, 8'h04, 8'h08,
                 8'h10, 8'h20, 8'h40, 8'h18, 8'h81, 8'h0F, 8'hF0, 8'h0B, 8'hD0,
                 8'h55, 8'hAA, 8'h07, 8'hE0};
    foreach (dir_bits[i]) begin
      case (i % 3)
        0:       send_sensor_beat(dir_bits[i], -11'sd1024);
        1:       send_sensor_beat(dir_bits[i], 11'sd1023);
        default: send_sensor_beat(dir_bits[i], pick_speed());
      endcase
    end
    wait_drained();

    phase_gain = '{16'hFFFF, 16'h0000, 16'h0001, GAIN_W'($urandom), 16'h0100,
                   GAIN_W'($urandom)};
    foreach (phase_gain[p]) begin
      write_gain(phase_gain[p]);
      // long receiver hold: the block fills and backs up the input
      if (p == 3) rx_hold = 500;
      if (p == 5) gaps_on = 1'b0;
      for (int n = 0; n < PHASE_BEATS; n++) begin
        // sender pause until every result is back
        if (p == 1 && n == PHASE_BEATS / 2) wait_drained();
        send_sensor_beat(pick_pattern(), pick_speed());
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
